@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL of the outlier-gated moving average.
// No dependencies; included by the core module, which carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define OGMA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define OGMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ogma_pkg.sv @@
// Shared constants for the outlier-gated moving average.
// No dependencies; used by every module of the block.
package ogma_pkg;

  localparam int DEPTH    = 5;
  localparam int SAMPLE_W = 16;
  localparam int HW_W     = 15;
  localparam logic [HW_W-1:0] HW_RESET = HW_W'(512);  // 2.0 degrees in Q8.8

  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(DEPTH);
  localparam int MAG_W  = SUM_W;

  // floor(m / DEPTH) = (m * RECIP) >> DIV_SHIFT for every m below 2**MAG_W
  localparam int DIV_SHIFT = MAG_W + $clog2(DEPTH);
  localparam int RECIP_W   = MAG_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** DIV_SHIFT) + DEPTH - 1) / DEPTH);

  // window compare width: sample, average and half-width sums without overflow
  localparam int CMP_W = SAMPLE_W + 2;

endpackage

@@ hw/rtl/ogma_cell.sv @@
// One history cell: holds a single sample and takes its neighbour's on shift.
// Depends on ogma_pkg.
module ogma_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 shift_i,
  input  logic signed [ogma_pkg::SAMPLE_W-1:0] data_i,
  output logic signed [ogma_pkg::SAMPLE_W-1:0] data_o
);

  logic signed [ogma_pkg::SAMPLE_W-1:0] data_q;
  logic signed [ogma_pkg::SAMPLE_W-1:0] data_d;

  assign data_d = shift_i ? data_i : data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

@@ hw/rtl/ogma_avg.sv @@
// History average: running sum divided by DEPTH, truncated toward zero.
// Reciprocal multiply on the magnitude, sign restored after. Depends on ogma_pkg.
module ogma_avg (
  input  logic signed [ogma_pkg::SUM_W-1:0]    sum_i,
  output logic signed [ogma_pkg::SAMPLE_W-1:0] avg_o
);

  localparam int PROD_W = ogma_pkg::MAG_W + ogma_pkg::RECIP_W;

  logic                              neg;
  logic [ogma_pkg::MAG_W-1:0]        mag;
  logic [PROD_W-1:0]                 prod;
  logic [ogma_pkg::SAMPLE_W-1:0]     quot;
  logic [ogma_pkg::SAMPLE_W:0]       avg_x;

  assign neg  = sum_i[ogma_pkg::SUM_W-1];
  assign mag  = neg ? (~ogma_pkg::MAG_W'(sum_i) + ogma_pkg::MAG_W'(1))
                    : ogma_pkg::MAG_W'(sum_i);
  assign prod = PROD_W'(mag) * PROD_W'(ogma_pkg::RECIP);
  assign quot = prod[ogma_pkg::DIV_SHIFT +: ogma_pkg::SAMPLE_W];

  // quotient is at most 2**15, so the negated value still fits 16 bits signed
  assign avg_x = neg ? (~{1'b0, quot} + (ogma_pkg::SAMPLE_W + 1)'(1)) : {1'b0, quot};
  assign avg_o = signed'(avg_x[ogma_pkg::SAMPLE_W-1:0]);

endmodule

@@ hw/rtl/outlier_gated_moving_average_core.sv @@
// Outlier-gated moving average, top level: cell row, running sum, window gate.
// Depends on ogma_pkg, ogma_cell, ogma_avg and assert_macros.svh.
//
// Usage:
//  - Input channel: sample_i with in_valid_i / in_stall_o. A word is taken at
//    a rising edge with in_valid_i high and in_stall_o low.
//  - Output channel: filtered_o, accepted_o, warming_up_o with out_valid_o /
//    out_stall_i. One result word per input word, in order.
//  - The result is written into the output register on the edge that takes
//    the sample. Throughput is one word per cycle while out_stall_i lets the
//    output register drain, set by the combinational loop running sum ->
//    reciprocal divide -> window compare -> cell shift enable.
//  - While the output register holds a word and out_stall_i is high,
//    in_stall_o is high; otherwise a new word may enter in the same cycle the
//    old one leaves.
//  - Reset clears the cell row, the running sum and the fill count, empties
//    the output register and loads the half-window with 2.0 degrees.
//  - cfg_we_i / cfg_wdata_i write the half-window; write only while idle.
`include "assert_macros.svh"

module outlier_gated_moving_average_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [ogma_pkg::HW_W-1:0]            cfg_wdata_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [ogma_pkg::SAMPLE_W-1:0] sample_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [ogma_pkg::SAMPLE_W-1:0] filtered_o,
  output logic                                 accepted_o,
  output logic                                 warming_up_o
);

  // half-window register
  logic [ogma_pkg::HW_W-1:0] hw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q <= ogma_pkg::HW_RESET;
    end else if (cfg_we_i) begin
      hw_q <= cfg_wdata_i;
    end
  end

  // handshake
  logic out_valid_q;
  logic in_fire;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;

  // fill count
  logic [ogma_pkg::FILL_W-1:0] fill_q;
  logic [ogma_pkg::FILL_W-1:0] fill_d;
  logic                        warming;

  assign warming = fill_q < ogma_pkg::FILL_W'(ogma_pkg::DEPTH);
  assign fill_d  = (in_fire && warming) ? fill_q + ogma_pkg::FILL_W'(1) : fill_q;

  // Cell row: oldest at index 0, new samples enter at the top end. During
  // warm-up the row shifts as well; the cells still hold their reset zeros,
  // so after DEPTH words the order matches slot-by-slot filling.
  logic signed [ogma_pkg::SAMPLE_W-1:0] hist [ogma_pkg::DEPTH];
  logic                                 shift_en;

  for (genvar g = 0; g < ogma_pkg::DEPTH; g++) begin : g_cell
    logic signed [ogma_pkg::SAMPLE_W-1:0] feed;
    if (g == ogma_pkg::DEPTH - 1) begin : g_top
      assign feed = sample_i;
    end else begin : g_mid
      assign feed = hist[g+1];
    end
    ogma_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift_en),
      .data_i (feed),
      .data_o (hist[g])
    );
  end

  // running sum of the row: drop the oldest, add the newcomer
  logic signed [ogma_pkg::SUM_W-1:0] sum_q;
  logic signed [ogma_pkg::SUM_W-1:0] sum_d;

  assign sum_d = shift_en
               ? sum_q - ogma_pkg::SUM_W'(hist[0]) + ogma_pkg::SUM_W'(sample_i)
               : sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      fill_q <= '0;
    end else begin
      sum_q  <= sum_d;
      fill_q <= fill_d;
    end
  end

  // average before update and window gate
  logic signed [ogma_pkg::SAMPLE_W-1:0] avg;
  logic signed [ogma_pkg::CMP_W-1:0]    s_x;
  logic signed [ogma_pkg::CMP_W-1:0]    a_x;
  logic signed [ogma_pkg::CMP_W-1:0]    h_x;
  logic                                 in_window;
  logic                                 take;

  ogma_avg u_avg (
    .sum_i(sum_q),
    .avg_o(avg)
  );

  assign s_x = ogma_pkg::CMP_W'(sample_i);
  assign a_x = ogma_pkg::CMP_W'(avg);
  assign h_x = signed'(ogma_pkg::CMP_W'(hw_q));

  // strict on both sides; a zero half-window admits no sample once warm-up is over
  assign in_window = (s_x < a_x + h_x) && (s_x > a_x - h_x);
  assign take      = warming | in_window;
  assign shift_en  = in_fire & take;

  // output register
  logic signed [ogma_pkg::SAMPLE_W-1:0] filt_q;
  logic                                 acc_q;
  logic                                 warm_q;
  logic                                 out_valid_d;

  assign out_valid_d = in_fire | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      filt_q <= warming ? sample_i : avg;
      acc_q  <= take;
      warm_q <= warming;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign filtered_o   = filt_q;
  assign accepted_o   = acc_q;
  assign warming_up_o = warm_q;

  // check: running sum equals the sum of the cells
  logic signed [ogma_pkg::SUM_W-1:0] sum_chk;

  always_comb begin
    sum_chk = '0;
    for (int i = 0; i < ogma_pkg::DEPTH; i++) begin
      sum_chk = sum_chk + ogma_pkg::SUM_W'(hist[i]);
    end
  end

  `OGMA_ASSERT(a_fill_bound, clk_i, rst_ni,
               fill_q <= ogma_pkg::FILL_W'(ogma_pkg::DEPTH),
               "fill count beyond history depth")
  `OGMA_ASSERT(a_sum_match, clk_i, rst_ni, sum_q == sum_chk,
               "running sum out of step with the cell row")
  `OGMA_ASSERT(a_warm_acc, clk_i, rst_ni, !(out_valid_o && warming_up_o) || accepted_o,
               "warm-up word not written to history")
  `OGMA_ASSERT_NEXT(a_sum_hold, clk_i, rst_ni, !shift_en, $stable(sum_q),
                    "running sum moved without a history write")

endmodule

@@ sim/outlier_gated_moving_average_core_tb.sv @@
// Self-checking testbench for outlier_gated_moving_average_core: a directed
// table, then random sample bursts under random output back-pressure.
// Depends on ogma_pkg and the RTL of the block; reads no files.
module outlier_gated_moving_average_core_tb;

  typedef logic signed [ogma_pkg::SAMPLE_W-1:0] sample_t;
  typedef logic [ogma_pkg::HW_W-1:0]            window_t;

  // One result word as the block presents it
  typedef struct packed {
    sample_t filtered;
    logic    accepted;
    logic    warming_up;
  } filter_result_t;

  typedef enum logic [0:0] {ROW_SAMPLE, ROW_WINDOW} row_kind_e;

  // Directed row: a sample word, or a half-window write done while idle
  typedef struct packed {
    row_kind_e      kind;
    sample_t        value;
    logic           has_exp;
    filter_result_t exp_res;
  } stim_row_t;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 6;
  localparam int WORDS_PER_PHASE = 66;
  localparam int SHOW_MAX        = 10;

  logic    clk_i;
  logic    rst_ni;
  logic    cfg_we;
  window_t cfg_wdata;
  logic    in_valid;
  logic    in_stall;
  sample_t sample_in;
  logic    out_valid;
  logic    out_stall;
  sample_t filtered;
  logic    accepted;
  logic    warming_up;

  // Shadow of the filter state
  sample_t history_model [ogma_pkg::DEPTH];
  int      fill_level;
  window_t window_model;

  filter_result_t pending_results [$];
  stim_row_t      dir_table [$];

  int cycle_count;
  int mismatches;
  int words_in;
  int words_out;
  int kept_count;
  int dropped_count;
  int window_writes;

  outlier_gated_moving_average_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .sample_i     (sample_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .filtered_o   (filtered),
    .accepted_o   (accepted),
    .warming_up_o (warming_up)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int history_average();
    int sum;
    sum = 0;
    for (int i = 0; i < ogma_pkg::DEPTH; i++) sum += history_model[i];
    return sum / ogma_pkg::DEPTH;  // int division truncates toward zero
  endfunction

  function automatic filter_result_t filter_step(sample_t s);
    filter_result_t r;
    int             avg;
    int             hw;
    if (fill_level < ogma_pkg::DEPTH) begin
      history_model[fill_level] = s;
      fill_level++;
      r.filtered   = s;
      r.accepted   = 1'b1;
      r.warming_up = 1'b1;
      kept_count++;
    end else begin
      avg = history_average();
      hw  = window_model;
      r.filtered   = sample_t'(avg);
      r.warming_up = 1'b0;
      // strictly inside the window; a zero window admits nothing
      if ((int'(s) < avg + hw) && (int'(s) > avg - hw)) begin
        for (int i = 0; i + 1 < ogma_pkg::DEPTH; i++) history_model[i] = history_model[i + 1];
        history_model[ogma_pkg::DEPTH - 1] = s;
        r.accepted = 1'b1;
        kept_count++;
      end else begin
        r.accepted = 1'b0;
        dropped_count++;
      end
    end
    return r;
  endfunction

  // ------------------------------------------------------------ table rows

  function automatic stim_row_t warm_row(sample_t s);
    stim_row_t row;
    row.kind                 = ROW_SAMPLE;
    row.value                = s;
    row.has_exp              = 1'b1;
    row.exp_res.filtered     = s;   // passed straight through while filling
    row.exp_res.accepted     = 1'b1;
    row.exp_res.warming_up   = 1'b1;
    return row;
  endfunction

  function automatic stim_row_t sample_row(sample_t s);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_SAMPLE;
    row.value   = s;
    row.has_exp = 1'b0;
    return row;
  endfunction

  function automatic stim_row_t window_row(window_t v);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_WINDOW;
    row.value = sample_t'(v);
    return row;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Offer one word and hold it until taken; the predictor runs on acceptance
  task automatic send_sample(sample_t s, logic typed, filter_result_t typed_res);
    filter_result_t r;
    @(negedge clk_i);
    in_valid  <= 1'b1;
    sample_in <= s;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    r = filter_step(s);
    pending_results.push_back(typed ? typed_res : r);
    words_in++;
  endtask

  task automatic idle_input(int n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid  <= 1'b0;
      sample_in <= sample_t'($urandom);  // junk while invalid
    end
  endtask

  // Sender holds off until every outstanding result has been seen
  task automatic drain();
    idle_input(1);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_window(window_t v);
    drain();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    window_model = v;
    window_writes++;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Mostly samples around the running average so the gate is exercised,
  // with exact window edges and some full-range noise
  function automatic sample_t pick_sample();
    int avg;
    int hw;
    int span;
    int v;
    int roll;
    avg  = history_average();
    hw   = window_model;
    roll = $urandom_range(99);
    if (roll < 25) begin
      v = int'($urandom_range(65535)) - 32768;
    end else if (roll < 40) begin
      case ($urandom_range(3))
        0:       v = avg + hw;
        1:       v = avg - hw;
        2:       v = avg + hw - 1;
        default: v = avg - hw + 1;
      endcase
    end else begin
      span = hw + 8;
      v    = avg + int'($urandom_range(2 * span)) - span;
    end
    if (v > 32767)  v = 32767;
    if (v < -32768) v = -32768;
    return sample_t'(v);
  endfunction

  // --------------------------------------------------------- output checker

  always @(posedge clk_i) begin
    filter_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      words_out++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("ERROR: unexpected result word filtered=%0d accepted=%0b warming=%0b",
                   filtered, accepted, warming_up);
      end else begin
        want = pending_results.pop_front();
        if (filtered !== want.filtered || accepted !== want.accepted ||
            warming_up !== want.warming_up) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display("ERROR: word %0d exp filtered=%0d acc=%0b warm=%0b, got %0d %0b %0b",
                     words_out, want.filtered, want.accepted, want.warming_up,
                     filtered, accepted, warming_up);
        end
      end
    end
  end

  // Receiver back-pressure: alternating quiet, random, periodic and heavy spells
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      case ((cycle_count / 97) % 4)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(99) < 30);
        2:       out_stall <= (cycle_count % 3 == 0);
        default: out_stall <= ($urandom_range(99) < 70);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR: run exceeded %0d cycles", CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // ------------------------------------------------------------------ stimulus

  initial begin
    int      burst_left;
    int      gap;
    window_t win;

    rst_ni     = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    sample_in  = '0;
    out_stall  = 1'b0;
    cycle_count   = 0;
    mismatches    = 0;
    words_in      = 0;
    words_out     = 0;
    kept_count    = 0;
    dropped_count = 0;
    window_writes = 0;
    for (int i = 0; i < ogma_pkg::DEPTH; i++) history_model[i] = '0;
    fill_level   = 0;
    window_model = ogma_pkg::HW_RESET;

    // Warm-up words pass through unchanged; a zero sample is an ordinary value
    dir_table.push_back(warm_row(16'sd0));
    dir_table.push_back(warm_row(-16'sd32768));
    dir_table.push_back(warm_row(16'sd32767));
    dir_table.push_back(warm_row(16'sd1));
    dir_table.push_back(warm_row(-16'sd1));
    // History full, average 0 under the reset window
    dir_table.push_back(sample_row(16'sd511));
    // average now 102: both window edges are outside, one step in is inside
    dir_table.push_back(sample_row(16'sd614));
    dir_table.push_back(sample_row(-16'sd410));
    dir_table.push_back(sample_row(-16'sd409));
    // Zero window: nothing gets in
    dir_table.push_back(window_row(15'd0));
    dir_table.push_back(sample_row(16'sd0));
    dir_table.push_back(sample_row(16'sd32767));
    dir_table.push_back(sample_row(-16'sd32768));
    // Widest window
    dir_table.push_back(window_row(15'd32767));
    dir_table.push_back(sample_row(16'sd32767));
    dir_table.push_back(sample_row(-16'sd32768));
    dir_table.push_back(sample_row(16'sd0));
    dir_table.push_back(sample_row(16'sd32767));
    // Back to two degrees
    dir_table.push_back(window_row(ogma_pkg::HW_RESET));
    dir_table.push_back(sample_row(16'sd256));
    dir_table.push_back(sample_row(-16'sd5));
    dir_table.push_back(sample_row(16'sd7));
    dir_table.push_back(sample_row(16'sd0));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_WINDOW)
        write_window(ogma_pkg::HW_W'(dir_table[i].value));
      else
        send_sample(dir_table[i].value, dir_table[i].has_exp, dir_table[i].exp_res);
    end

    burst_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       win = ogma_pkg::HW_RESET;
        1:       win = '0;
        2:       win = '1;
        3:       win = 15'd1;
        4:       win = window_t'($urandom_range(2, 2048));
        default: win = window_t'($urandom_range(32767));
      endcase
      write_window(win);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
          idle_input(gap);
        end
        burst_left--;
        send_sample(pick_sample(), 1'b0, '0);
      end
    end

    drain();
    repeat (4) @(posedge clk_i);

    $display("Summary: %0d sample words in, %0d result words checked, %0d half-window writes",
             words_in, words_out, window_writes);
    $display("Summary: %0d samples kept, %0d rejected as outliers, %0d mismatches",
             kept_count, dropped_count, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ outlier_gated_moving_average_core.f @@
+incdir+hw/rtl
hw/rtl/ogma_pkg.sv
hw/rtl/ogma_cell.sv
hw/rtl/ogma_avg.sv
hw/rtl/outlier_gated_moving_average_core.sv
sim/outlier_gated_moving_average_core_tb.sv
